// ===== rtl/repm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package repm_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_PAIRED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Per-entry occupancy code kept in the table word
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_DEAD  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_ISSUE,
    FSM_EVAL
  } fsm_e;

  typedef struct packed {
    logic [FIELD_W-1:0] source_node;
    logic [FIELD_W-1:0] target_node;
    logic [FIELD_W-1:0] edge_id;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] current_edge;
    logic [FIELD_W-1:0] reverse_edge;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/reverse_edge_pair_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pairs each directed edge with its reverse. An edge with source below target is
// stored in a hashed table of TABLE_DEPTH entries (one single-port-read RAM,
// linear probing, freed entries left as tombstones) and gives no result; any other
// edge looks up (target,source) and gives one result: paired with the stored edge
// id, or reverse not found. An insert into a full table gives a table-full result.
// An item is taken when start is high and busy is low; busy then stays high while
// 1 up to TABLE_DEPTH table entries are probed: each probe is one RAM read, issued
// back to back, and the probe ends at a matching key, a never-used entry or after a
// full sweep. The result, if any, is on the ports in the first cycle that busy is
// low again, and a new item is taken only once the last one is through. The result
// strobe result_valid_o is high for one cycle and cannot be held off. After reset
// busy stays high while the table is swept to empty.
module reverse_edge_pair_matcher #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned NODE_BITS   = 32,
  parameter int unsigned EDGE_BITS   = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire repm_pkg::in_item_t   item_i,
  output logic                      result_valid_o,
  output repm_pkg::out_item_t       result_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W   = 2 * NODE_BITS;
  localparam int unsigned ENTRY_W = 2 + KEY_W + EDGE_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Fold the key onto the index bits, then bring it below the depth
  function automatic logic [IDX_W-1:0] hash_idx(input logic [KEY_W-1:0] key);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0]   hx;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    hx = {1'b0, h};
    if (hx >= DEPTH_X) begin
      hx = hx - DEPTH_X;
    end
    return hx[IDX_W-1:0];
  endfunction

  repm_pkg::fsm_e state_q, state_d;

  logic [KEY_W-1:0]     key_q, key_d;
  logic [EDGE_BITS-1:0] eid_q, eid_d;
  logic                 ins_q, ins_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     probes_q, probes_d;
  logic [IDX_W-1:0]     free_q, free_d;
  logic                 have_free_q, have_free_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                  res_valid_q, res_valid_d;
  repm_pkg::out_item_t   res_q, res_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [NODE_BITS-1:0] src_m, dst_m;
  logic [KEY_W-1:0]     in_key;
  logic                 in_ins;

  repm_pkg::slot_e      ent_state;
  logic [KEY_W-1:0]     ent_key;
  logic [EDGE_BITS-1:0] ent_eid;
  logic                 hit, last_probe, stop, ent_free;
  logic [IDX_W-1:0]     next_idx, free_idx;

  repm_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign src_m  = item_i.source_node[NODE_BITS-1:0];
  assign dst_m  = item_i.target_node[NODE_BITS-1:0];
  assign in_ins = src_m < dst_m;
  assign in_key = in_ins ? {src_m, dst_m} : {dst_m, src_m};

  assign ent_state  = repm_pkg::slot_e'(ram_rdata[ENTRY_W-1 -: 2]);
  assign ent_key    = ram_rdata[EDGE_BITS +: KEY_W];
  assign ent_eid    = ram_rdata[EDGE_BITS-1:0];
  assign hit        = (ent_state == repm_pkg::SLOT_USED) && (ent_key == key_q);
  assign last_probe = probes_q == LAST_IDX;
  assign stop       = (ent_state == repm_pkg::SLOT_EMPTY) || last_probe;
  assign ent_free   = ent_state != repm_pkg::SLOT_USED;
  assign next_idx   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign free_idx   = have_free_q ? free_q : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= repm_pkg::FSM_CLEAR;
      idx_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    eid_q       <= eid_d;
    ins_q       <= ins_d;
    probes_q    <= probes_d;
    free_q      <= free_d;
    have_free_q <= have_free_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    eid_d       = eid_q;
    ins_d       = ins_q;
    idx_d       = idx_q;
    probes_d    = probes_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {repm_pkg::SLOT_USED, key_q, eid_q};
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    unique case (state_q)
      repm_pkg::FSM_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {repm_pkg::SLOT_EMPTY, {(KEY_W + EDGE_BITS){1'b0}}};
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = repm_pkg::FSM_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      repm_pkg::FSM_IDLE: begin
        if (start) begin
          key_d       = in_key;
          eid_d       = item_i.edge_id[EDGE_BITS-1:0];
          ins_d       = in_ins;
          idx_d       = hash_idx(in_key);
          probes_d    = '0;
          have_free_d = 1'b0;
          state_d     = repm_pkg::FSM_ISSUE;
        end
      end

      repm_pkg::FSM_ISSUE: begin
        ram_re  = 1'b1;
        state_d = repm_pkg::FSM_EVAL;
      end

      repm_pkg::FSM_EVAL: begin
        res_d.current_edge = repm_pkg::FIELD_W'(eid_q);
        res_d.reverse_edge = '0;
        res_d.status       = repm_pkg::ST_MISSING;
        if (hit) begin
          state_d = repm_pkg::FSM_IDLE;
          if (!ins_q) begin
            // Leave a tombstone so later probes walk past this entry
            ram_we             = 1'b1;
            ram_waddr          = idx_q;
            ram_wdata          = {repm_pkg::SLOT_DEAD, ent_key, ent_eid};
            count_d            = count_q - 1'b1;
            res_valid_d        = 1'b1;
            res_d.status       = repm_pkg::ST_PAIRED;
            res_d.reverse_edge = repm_pkg::FIELD_W'(ent_eid);
          end
        end else if (stop) begin
          state_d = repm_pkg::FSM_IDLE;
          if (!ins_q) begin
            res_valid_d = 1'b1;
          end else if (count_q == DEPTH_CNT) begin
            res_valid_d  = 1'b1;
            res_d.status = repm_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = {repm_pkg::SLOT_USED, key_q, eid_q};
            count_d   = count_q + 1'b1;
          end
        end else begin
          // Advance the probe and remember the first reusable entry
          if (ent_free && !have_free_q) begin
            free_d      = idx_q;
            have_free_d = 1'b1;
          end
          idx_d     = next_idx;
          probes_d  = probes_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = next_idx;
        end
      end

      default: begin
        state_d = repm_pkg::FSM_IDLE;
      end
    endcase
  end

  assign busy           = state_q != repm_pkg::FSM_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting an item");

  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_d |-> (state_q == repm_pkg::FSM_EVAL))
    else $error("result raised outside probe evaluation");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("table read and write to the same entry in one cycle");

  a_pair_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_d && (res_d.status == repm_pkg::ST_PAIRED)) |=>
      (count_q == $past(count_q) - 1'b1))
    else $error("paired result without freeing an entry");
`endif

endmodule

`default_nettype wire

// ===== rtl/repm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module repm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 98
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
